/* sv/nna_pkg.sv */
// Package with the shared codes and constants of the activation unit.
package nna_pkg;

    typedef enum logic [1:0] {
        KIND_IDENTITY = 2'd0,
        KIND_RELU     = 2'd1,
        KIND_LEAKY    = 2'd2,
        KIND_SOFTMAX  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        CFG_KIND  = 2'd0,
        CFG_DERIV = 2'd1,
        CFG_SLOPE = 2'd2,
        CFG_NONE  = 2'd3
    } t_cfg_index;

    localparam logic [31:0] LN2_Q32      = 32'd2977044472;
    localparam logic [3:0]  TAYLOR_TERMS = 4'd14;
    localparam logic [5:0]  K_LIMIT      = 6'd33;
    localparam logic [15:0] SLOPE_RESET  = 16'd655;

endpackage

/* sv/nn_activation_unit.sv */
// Top level of the vector activation unit with the softmax element store.
// Elementwise modes (identity, ReLU, leaky ReLU, every derivative) take one
// cycle per element unless the output stalls, and answer each element with
// one result. Softmax forward stores one element per cycle, unless the output
// stalls, in a single-port-write memory; after the last element the block runs
// two passes over the stored vector. The first pass computes each exponential
// in a sequential unit: range reduction by ln 2, then 14 Taylor terms, each
// divided in the 32-bit serial divider. The second pass divides each
// exponential by the sum in a serial divider with a 32 + FRAC_BITS bit
// quotient: each element is read, divided and sent out, and the output can stall.
// No input is accepted during these passes.
module nn_activation_unit #(
    parameter int MAX_LEN   = 64,
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [31:0] i_element_value,
    input  logic               i_last_element,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_result_value,
    output logic               o_last_result
);
    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int QW = 32 + FRAC_BITS;

    typedef enum logic [7:0] {
        S_IDLE = 8'b00000001,
        S_RD1  = 8'b00000010,
        S_EXPS = 8'b00000100,
        S_EXPW = 8'b00001000,
        S_RD2  = 8'b00010000,
        S_DIVS = 8'b00100000,
        S_DIVW = 8'b01000000,
        S_OUT  = 8'b10000000
    } t_state;

    t_state             r_state, n_state;
    logic [1:0]         r_kind;
    logic               r_deriv;
    logic [15:0]        r_slope;
    logic [CW-1:0]      r_count, n_count;
    logic signed [31:0] r_max, n_max;
    logic [31:0]        r_sum, n_sum;
    logic [AW-1:0]      r_idx, n_idx;
    logic [31:0]        r_quot, n_quot;
    logic               r_out_valid, n_out_valid;
    logic signed [31:0] r_out_value, n_out_value;
    logic               r_out_last, n_out_last;

    logic [31:0]        mem [MAX_LEN];
    logic [31:0]        r_rd_data;
    logic               we;
    logic [AW-1:0]      waddr;
    logic [31:0]        wdata;

    logic               sm_fwd;
    logic               in_acc;
    logic               out_free;
    logic               idx_last;
    logic signed [31:0] ew_y;
    logic [32:0]        neg_d;
    logic               exp_start;
    logic               exp_done;
    logic [31:0]        exp_val;
    logic [32:0]        sum_add;
    logic               div_start;
    logic               div_done;
    logic [QW-1:0]      div_q;
    logic               out_load_last;

    nna_elem #(.FRAC_BITS(FRAC_BITS)) u_elem (
        .i_x     (i_element_value),
        .i_kind  (r_kind),
        .i_deriv (r_deriv),
        .i_slope (r_slope),
        .o_y     (ew_y)
    );

    nna_exp #(.FRAC_BITS(FRAC_BITS)) u_exp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (exp_start),
        .i_neg_d (neg_d[31:0]),
        .o_done  (exp_done),
        .o_exp   (exp_val)
    );

    nna_div #(.NW(QW), .DW(32)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   ({r_rd_data, {FRAC_BITS{1'b0}}}),
        .i_den   (r_sum),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    assign o_cfg_ready = 1'b1;
    assign sm_fwd      = (r_kind == nna_pkg::KIND_SOFTMAX) && !r_deriv;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE) && out_free;
    assign in_acc      = i_in_valid && o_in_ready;
    assign idx_last    = (CW'(r_idx) + CW'(1)) == r_count;
    assign neg_d       = {r_max[31], r_max} - {r_rd_data[31], r_rd_data};
    assign sum_add     = {1'b0, r_sum} + {1'b0, exp_val};

    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_max         = r_max;
        n_sum         = r_sum;
        n_idx         = r_idx;
        n_quot        = r_quot;
        n_out_valid   = r_out_valid;
        n_out_value   = r_out_value;
        n_out_last    = r_out_last;
        we            = 1'b0;
        waddr         = r_idx;
        wdata         = exp_val;
        exp_start     = 1'b0;
        div_start     = 1'b0;
        out_load_last = 1'b0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (sm_fwd) begin
                        if (r_count < CW'(MAX_LEN)) begin
                            we      = 1'b1;
                            waddr   = r_count[AW-1:0];
                            wdata   = i_element_value;
                            n_count = r_count + CW'(1);
                            if (r_count == '0 || i_element_value > r_max) begin
                                n_max = i_element_value;
                            end
                        end
                        if (i_last_element) begin
                            n_idx   = '0;
                            n_sum   = '0;
                            n_state = S_RD1;
                        end
                    end else begin
                        n_out_valid = 1'b1;
                        n_out_value = ew_y;
                        n_out_last  = i_last_element;
                    end
                end
            end
            S_RD1: n_state = S_EXPS;
            S_EXPS: begin
                exp_start = 1'b1;
                n_state   = S_EXPW;
            end
            S_EXPW: begin
                if (exp_done) begin
                    we    = 1'b1;
                    n_sum = sum_add[32] ? 32'hFFFF_FFFF : sum_add[31:0];
                    if (idx_last) begin
                        n_idx   = '0;
                        n_state = S_RD2;
                    end else begin
                        n_idx   = r_idx + AW'(1);
                        n_state = S_RD1;
                    end
                end
            end
            S_RD2: n_state = S_DIVS;
            S_DIVS: begin
                div_start = 1'b1;
                n_state   = S_DIVW;
            end
            S_DIVW: begin
                if (div_done) begin
                    n_quot  = (r_sum == '0) ? '0 : div_q[31:0];
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_value = r_quot;
                    n_out_last  = idx_last;
                    if (idx_last) begin
                        out_load_last = 1'b1;
                        n_count       = '0;
                        n_max         = '0;
                        n_sum         = '0;
                        n_state       = S_IDLE;
                    end else begin
                        n_idx   = r_idx + AW'(1);
                        n_state = S_RD2;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        r_rd_data <= mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_kind      <= nna_pkg::KIND_IDENTITY;
            r_deriv     <= 1'b0;
            r_slope     <= nna_pkg::SLOPE_RESET;
            r_count     <= '0;
            r_max       <= '0;
            r_sum       <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_max       <= n_max;
            r_sum       <= n_sum;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    nna_pkg::CFG_KIND:  r_kind  <= i_cfg_data[1:0];
                    nna_pkg::CFG_DERIV: r_deriv <= i_cfg_data[0];
                    nna_pkg::CFG_SLOPE: r_slope <= i_cfg_data;
                    default: ;
                endcase
            end
        end
        r_quot      <= n_quot;
        r_out_value <= n_out_value;
        r_out_last  <= n_out_last;
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_value = r_out_value;
    assign o_last_result  = r_out_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_LEN))
        else $error("element count exceeds store depth");

    a_idx_in_vector: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (CW'(r_idx) < r_count))
        else $error("softmax pass index outside the stored vector");

    a_pass_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load_last |=> (r_count == '0 && r_state == S_IDLE && o_last_result))
        else $error("softmax pass did not close the vector");

    a_no_input_in_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_in_ready)
        else $error("input ready during softmax pass");
endmodule

/* sv/nna_div.sv */
// Serial restoring divider producing one quotient bit per cycle.
module nna_div #(
    parameter int NW = 32,
    parameter int DW = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [NW-1:0] o_quot
);
    localparam int CW = $clog2(NW + 1);

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [NW-1:0] r_num, n_num;
    logic [NW-1:0] r_quot, n_quot;
    logic [DW:0]   r_rem, n_rem;
    logic [DW-1:0] r_den, n_den;
    logic [DW:0]   rem_sh;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_num  = r_num;
        n_quot = r_quot;
        n_rem  = r_rem;
        n_den  = r_den;
        rem_sh = {r_rem[DW-1:0], r_num[NW-1]};
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CW'(NW);
            n_num  = i_num;
            n_den  = i_den;
            n_rem  = '0;
            n_quot = '0;
        end else if (r_busy) begin
            n_num = {r_num[NW-2:0], 1'b0};
            if (rem_sh >= {1'b0, r_den}) begin
                n_rem  = rem_sh - {1'b0, r_den};
                n_quot = {r_quot[NW-2:0], 1'b1};
            end else begin
                n_rem  = rem_sh;
                n_quot = {r_quot[NW-2:0], 1'b0};
            end
            n_cnt = r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_num  <= n_num;
        r_quot <= n_quot;
        r_rem  <= n_rem;
        r_den  <= n_den;
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule

/* sv/nna_exp.sv */
// Sequential exponential unit: range reduction by ln 2 and a Taylor series.
module nna_exp #(
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_neg_d,
    output logic        o_done,
    output logic [31:0] o_exp
);
    localparam int AW = 64 - FRAC_BITS;

    typedef enum logic [5:0] {
        E_IDLE = 6'b000001,
        E_RED  = 6'b000010,
        E_MUL  = 6'b000100,
        E_DST  = 6'b001000,
        E_DWT  = 6'b010000,
        E_FIN  = 6'b100000
    } t_estate;

    t_estate             r_state, n_state;
    logic [AW-1:0]       r_a, n_a;
    logic [5:0]          r_k, n_k;
    logic [31:0]         r_r, n_r;
    logic [32:0]         r_term, n_term;
    logic signed [34:0]  r_acc, n_acc;
    logic [3:0]          r_i, n_i;
    logic [63:0]         r_prod, n_prod;
    logic                r_done, n_done;
    logic [31:0]         r_exp, n_exp;
    logic                div_start;
    logic                div_done;
    logic [31:0]         div_q;
    logic [34:0]         acc_pos;
    logic [34:0]         acc_sh;

    nna_div #(.NW(32), .DW(4)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_prod[63:32]),
        .i_den   (r_i),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    always_comb begin
        n_state   = r_state;
        n_a       = r_a;
        n_k       = r_k;
        n_r       = r_r;
        n_term    = r_term;
        n_acc     = r_acc;
        n_i       = r_i;
        n_prod    = r_prod;
        n_done    = 1'b0;
        n_exp     = r_exp;
        div_start = 1'b0;
        acc_pos   = r_acc[34] ? '0 : r_acc;
        acc_sh    = acc_pos >> r_k;
        case (r_state)
            E_IDLE: begin
                if (i_start) begin
                    n_a     = {i_neg_d, {(32 - FRAC_BITS){1'b0}}};
                    n_k     = '0;
                    n_state = E_RED;
                end
            end
            E_RED: begin
                if (r_k == nna_pkg::K_LIMIT) begin
                    n_exp   = '0;
                    n_done  = 1'b1;
                    n_state = E_IDLE;
                end else if (r_a >= AW'(nna_pkg::LN2_Q32)) begin
                    n_a = r_a - AW'(nna_pkg::LN2_Q32);
                    n_k = r_k + 6'd1;
                end else begin
                    n_r     = r_a[31:0];
                    n_term  = 33'h1_0000_0000;
                    n_acc   = 35'sh1_0000_0000;
                    n_i     = 4'd1;
                    n_state = E_MUL;
                end
            end
            E_MUL: begin
                n_prod  = r_term[32] ? {r_r, 32'd0} : (64'(r_term[31:0]) * 64'(r_r));
                n_state = E_DST;
            end
            E_DST: begin
                div_start = 1'b1;
                n_state   = E_DWT;
            end
            E_DWT: begin
                if (div_done) begin
                    n_term = {1'b0, div_q};
                    if (r_i[0]) begin
                        n_acc = r_acc - $signed({3'b000, div_q});
                    end else begin
                        n_acc = r_acc + $signed({3'b000, div_q});
                    end
                    if (r_i == nna_pkg::TAYLOR_TERMS) begin
                        n_state = E_FIN;
                    end else begin
                        n_i     = r_i + 4'd1;
                        n_state = E_MUL;
                    end
                end
            end
            E_FIN: begin
                n_exp   = 32'(acc_sh >> (32 - FRAC_BITS));
                n_done  = 1'b1;
                n_state = E_IDLE;
            end
            default: n_state = E_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= E_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_a    <= n_a;
        r_k    <= n_k;
        r_r    <= n_r;
        r_term <= n_term;
        r_acc  <= n_acc;
        r_i    <= n_i;
        r_prod <= n_prod;
        r_exp  <= n_exp;
    end

    assign o_done = r_done;
    assign o_exp  = r_exp;
endmodule

/* sv/nna_elem.sv */
// Elementwise functions and derivatives for identity, ReLU and leaky ReLU.
module nna_elem #(
    parameter int FRAC_BITS = 16
) (
    input  logic signed [31:0] i_x,
    input  logic [1:0]         i_kind,
    input  logic               i_deriv,
    input  logic [15:0]        i_slope,
    output logic signed [31:0] o_y
);
    localparam logic [31:0] ONE = 32'(1) << FRAC_BITS;

    logic signed [48:0] leak_prod;
    logic [47:0]        slope_sh;
    logic               neg;

    always_comb begin
        neg       = i_x[31];
        leak_prod = $signed({1'b0, i_slope}) * 49'(i_x);
        slope_sh  = {i_slope, 32'd0} >> (32 - FRAC_BITS + 16);
        o_y       = i_x;
        if (!i_deriv) begin
            case (i_kind)
                nna_pkg::KIND_RELU:  o_y = neg ? '0 : i_x;
                nna_pkg::KIND_LEAKY: o_y = neg ? 32'(leak_prod >>> 16) : i_x;
                default:             o_y = i_x;
            endcase
        end else begin
            case (i_kind)
                nna_pkg::KIND_RELU:  o_y = neg ? '0 : ONE;
                nna_pkg::KIND_LEAKY: o_y = neg ? slope_sh[31:0] : ONE;
                default:             o_y = ONE;
            endcase
        end
    end
endmodule
